// ===== sv/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse: adjugate index table and
// pipeline depths.
// ----------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

	// low quotient magnitude bits kept by each divider lane
	localparam int MAG_BITS = 64;

	// products, cofactors, det partial products, det sum
	localparam int FRONT_LAT = 4;

	// numerator width of a divider lane; one quotient bit per numerator bit
	function automatic int lane_num_bits(int w, int f, int dw);
		int nw;
		nw = (2*w + 2*f + 2 > dw) ? 2*w + 2*f + 3 : dw + 1;
		return (nw > MAG_BITS) ? nw : MAG_BITS + 1;
	endfunction

	// adjugate entry k (row-major) = m[p]*m[q] - m[r]*m[s]
	localparam int ADJ_IDX [9][4] = '{
		'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
		'{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
	};

endpackage

`default_nettype wire

// ===== sv/matrix_3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// Signed fixed-point 3x3 inverse: exact adjugate and determinant, nine
// divider lanes side by side, merge stage for singular and saturation.
// ----------------------------------------------------------------------------
// Pipeline from start to done: 4 front stages, 102 divider lane stages
//   (setup, one quotient bit per stage over 100 numerator bits,
//   rounding/clamp) and 1 merge stage.
// Throughput: one item per cycle; busy is always low.
// Reset clears the valid pipeline only; no items are in flight after reset.
`default_nettype none

module matrix_3x3_inverse
	import m3i_pkg::*;
#(
	parameter int ENTRY_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic signed [ENTRY_WIDTH-1:0] m00,
	input  logic signed [ENTRY_WIDTH-1:0] m01,
	input  logic signed [ENTRY_WIDTH-1:0] m02,
	input  logic signed [ENTRY_WIDTH-1:0] m10,
	input  logic signed [ENTRY_WIDTH-1:0] m11,
	input  logic signed [ENTRY_WIDTH-1:0] m12,
	input  logic signed [ENTRY_WIDTH-1:0] m20,
	input  logic signed [ENTRY_WIDTH-1:0] m21,
	input  logic signed [ENTRY_WIDTH-1:0] m22,
	output logic signed [ENTRY_WIDTH-1:0] r00,
	output logic signed [ENTRY_WIDTH-1:0] r01,
	output logic signed [ENTRY_WIDTH-1:0] r02,
	output logic signed [ENTRY_WIDTH-1:0] r10,
	output logic signed [ENTRY_WIDTH-1:0] r11,
	output logic signed [ENTRY_WIDTH-1:0] r12,
	output logic signed [ENTRY_WIDTH-1:0] r20,
	output logic signed [ENTRY_WIDTH-1:0] r21,
	output logic signed [ENTRY_WIDTH-1:0] r22,
	output logic                          singular,
	output logic                          saturated
);

	localparam int W        = ENTRY_WIDTH;
	localparam int DW       = 3 * W + 3;
	localparam int LANE_LAT = lane_num_bits(W, FRAC_BITS, DW) + 2;
	localparam int LAT      = FRONT_LAT + LANE_LAT + 1;

	logic signed [W-1:0]   m_in [9];
	logic signed [2*W:0]   adj  [9];
	logic signed [DW-1:0]  det;
	logic signed [W-1:0]   res_l [9];
	logic [8:0]            sat_l;

	logic [LAT-1:0]        vld_q;
	logic [LANE_LAT-1:0]   sing_q;
	logic signed [W-1:0]   r_q [9];
	logic                  singular_q;
	logic                  saturated_q;

	assign m_in = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	m3i_front #(.W(W), .DW(DW)) u_front (
		.clk (clk),
		.m   (m_in),
		.adj (adj),
		.det (det)
	);

	for (genvar k = 0; k < 9; k++) begin : g_lane
		m3i_lane #(.W(W), .F(FRAC_BITS), .DW(DW)) u_lane (
			.clk (clk),
			.adj (adj[k]),
			.det (det),
			.res (res_l[k]),
			.sat (sat_l[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	// merge: singular item forces zero entries and no saturation
	always_ff @(posedge clk) begin
		sing_q      <= {sing_q[LANE_LAT-2:0], det == '0};
		singular_q  <= sing_q[LANE_LAT-1];
		saturated_q <= !sing_q[LANE_LAT-1] && (|sat_l);
		for (int k = 0; k < 9; k++) begin
			r_q[k] <= sing_q[LANE_LAT-1] ? '0 : res_l[k];
		end
	end

	assign busy      = 1'b0;
	assign done      = vld_q[LAT-1];
	assign singular  = singular_q;
	assign saturated = saturated_q;
	assign r00 = r_q[0];
	assign r01 = r_q[1];
	assign r02 = r_q[2];
	assign r10 = r_q[3];
	assign r11 = r_q[4];
	assign r12 = r_q[5];
	assign r20 = r_q[6];
	assign r21 = r_q[7];
	assign r22 = r_q[8];

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without an item accepted LAT cycles earlier");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && singular |-> !saturated && r00 == '0 && r11 == '0 && r22 == '0)
		else $error("singular item with nonzero result or saturation");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a fully pipelined block");

endmodule

`default_nettype wire

// ===== sv/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front
// Products, adjugate and determinant of one matrix, exact, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_front
	import m3i_pkg::*;
#(
	parameter int W  = 32,
	parameter int DW = 3 * W + 3
) (
	input  logic                 clk,
	input  logic signed [W-1:0]  m   [9],
	output logic signed [2*W:0]  adj [9],
	output logic signed [DW-1:0] det
);

	logic signed [2*W-1:0]  p_s1 [9];
	logic signed [2*W-1:0]  s_s1 [9];
	logic signed [W-1:0]    m_s1 [3];
	logic signed [W-1:0]    m_s2 [3];
	logic signed [2*W:0]    adj_s2 [9];
	logic signed [2*W:0]    adj_s3 [9];
	logic signed [2*W:0]    adj_s4 [9];
	logic signed [2*W:0]    pl_s3 [3];
	logic signed [2*W:0]    ph_s3 [3];
	logic signed [DW-1:0]   det_s4;
	logic signed [DW-1:0]   det_sum;

	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			p_s1[k]   <= m[ADJ_IDX[k][0]] * m[ADJ_IDX[k][1]];
			s_s1[k]   <= m[ADJ_IDX[k][2]] * m[ADJ_IDX[k][3]];
			adj_s2[k] <= (2*W+1)'(p_s1[k]) - (2*W+1)'(s_s1[k]);
			adj_s3[k] <= adj_s2[k];
			adj_s4[k] <= adj_s3[k];
		end
	end

	// det = m0*adj0 + m1*adj3 + m2*adj6, adjugate split into low and high halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			m_s1[j]  <= m[j];
			m_s2[j]  <= m_s1[j];
			pl_s3[j] <= m_s2[j] * $signed({1'b0, adj_s2[3*j][W-1:0]});
			ph_s3[j] <= m_s2[j] * $signed(adj_s2[3*j][2*W:W]);
		end
	end

	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + (DW'(ph_s3[j]) <<< W) + DW'(pl_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		det_s4 <= det_sum;
	end

	assign adj = adj_s4;
	assign det = det_s4;

endmodule

`default_nettype wire

// ===== sv/m3i_lane.sv =====
// ----------------------------------------------------------------------------
// m3i_lane
// One divider lane: rounded adj * 2^(2F) / det, restoring division with one
// quotient bit per stage, then clamp to the entry range.
// ----------------------------------------------------------------------------
`default_nettype none

module m3i_lane
	import m3i_pkg::*;
#(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int DW = 3 * W + 3
) (
	input  logic                 clk,
	input  logic signed [2*W:0]  adj,
	input  logic signed [DW-1:0] det,
	output logic signed [W-1:0]  res,
	output logic                 sat
);

	localparam int NW   = lane_num_bits(W, F, DW);
	localparam int DENW = DW + 1;
	localparam logic [MAG_BITS-1:0] LIM = MAG_BITS'(1) << (W - 1);

	logic [2*W:0]           adj_mag;
	logic [DW-1:0]          det_mag;
	logic [NW-1:0]          num;
	logic [DENW-1:0]        den;

	logic [DENW-1:0]        rem_s  [NW+1];
	logic [DENW-1:0]        den_s  [NW+1];
	logic [NW-1:0]          nlo_s  [NW+1];
	logic [MAG_BITS-1:0]    quo_s  [NW+1];
	logic                   over_s [NW+1];
	logic                   sgn_s  [NW+1];

	logic [MAG_BITS-1:0]    mag;
	logic                   neg;
	logic                   clamp;
	logic [MAG_BITS-1:0]    mag_c;
	logic signed [W-1:0]    res_q;
	logic                   sat_q;

	always_comb begin
		adj_mag = adj[2*W] ? (~adj + 1'b1) : adj;
		det_mag = det[DW-1] ? (~det + 1'b1) : det;
		num     = (NW'(adj_mag) << (2*F + 1)) + NW'(det_mag);
		den     = {det_mag, 1'b0};
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		den_s[0]  <= den;
		nlo_s[0]  <= num;
		quo_s[0]  <= '0;
		over_s[0] <= 1'b0;
		sgn_s[0]  <= adj[2*W] ^ det[DW-1];
	end

	// quotient bits shifted out above MAG_BITS mark an overflow
	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DENW:0] sh;
		logic          ge;
		logic [DENW:0] diff;

		always_comb begin
			sh   = {rem_s[i], nlo_s[i][NW-1]};
			ge   = sh >= {1'b0, den_s[i]};
			diff = sh - {1'b0, den_s[i]};
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[DENW-1:0] : sh[DENW-1:0];
			den_s[i+1]  <= den_s[i];
			nlo_s[i+1]  <= {nlo_s[i][NW-2:0], 1'b0};
			quo_s[i+1]  <= {quo_s[i][MAG_BITS-2:0], ge};
			over_s[i+1] <= over_s[i] | quo_s[i][MAG_BITS-1];
			sgn_s[i+1]  <= sgn_s[i];
		end
	end

	always_comb begin
		mag   = quo_s[NW];
		neg   = sgn_s[NW] && (mag != '0);
		clamp = over_s[NW] || (mag > (neg ? LIM : LIM - 1'b1));
		mag_c = clamp ? (neg ? LIM : LIM - 1'b1) : mag;
	end

	always_ff @(posedge clk) begin
		res_q <= W'(neg ? ('0 - mag_c) : mag_c);
		sat_q <= clamp;
	end

	assign res = res_q;
	assign sat = sat_q;

endmodule

`default_nettype wire
